/* hw/rtl/lpht_pkg.sv */
package lpht_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int KEY_W       = 31;
    localparam int CFG_W       = 32;
    localparam int PROBE_STEP  = 17;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_SEARCH = 2'd1,
        REQ_DELETE = 2'd2
    } req_type_t;

    typedef enum logic [2:0] {
        RES_INSERTED  = 3'd0,
        RES_FULL      = 3'd1,
        RES_FOUND     = 3'd2,
        RES_NOT_FOUND = 3'd3,
        RES_DELETED   = 3'd4,
        RES_DEL_MISS  = 3'd5
    } res_status_t;

    typedef enum logic [1:0] {
        SLOT_EMPTY = 2'd0,
        SLOT_LIVE  = 2'd1,
        SLOT_DEAD  = 2'd2
    } slot_state_t;

    typedef enum logic {
        CFG_HASH_MULT = 1'b0,
        CFG_HASH_ADD  = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        SEQ_CLEAR,
        SEQ_IDLE,
        SEQ_HASH,
        SEQ_READ,
        SEQ_CHECK,
        SEQ_REPLY
    } seq_state_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [1:0]       state;
    } entry_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        entry_t            wdata;
        logic [SLOT_W-1:0] raddr;
    } mem_req_t;

endpackage

/* hw/rtl/lpht_if.sv */
interface lpht_req_if
    import lpht_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [1:0]       req_type;
    logic [KEY_W-1:0] key;

    modport source (output valid, output req_type, output key, input ready);
    modport sink   (input valid, input req_type, input key, output ready);
endinterface

interface lpht_rsp_if
    import lpht_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  live_count;

    modport source (output valid, output status, output slot, output live_count, input ready);
    modport sink   (input valid, input status, input slot, input live_count, output ready);
endinterface

/* hw/rtl/linear_probe_hash_table.sv */
// Channel  Dir  Handshake            Payload
// req      in   req.valid/req.ready  req_type[1:0], key[30:0]
// rsp      out  rsp.valid/rsp.ready  status[2:0], slot[9:0], live_count[10:0]
// cfg      in   cfg_we               cfg_index (0 hash_mult, 1 hash_add), cfg_data[31:0]
//
// Flow: a request is hashed to its home slot, then makes P probes before the result
// register is loaded; each probe is one read of the slot memory plus one check.
// An insert into a full table skips the hash and the probes.
// Reset: after rst_n rises, a clearing pass marks all 1024 slots empty, one per
// cycle; req.ready stays low until the pass ends. Config writes are taken anytime.
// Stalls: a held result does not block a new request; a second result waits.
module linear_probe_hash_table
    import lpht_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    lpht_req_if.sink         req,
    lpht_rsp_if.source       rsp
);

    logic              hash_start;
    logic [KEY_W-1:0]  hash_key;
    logic [SLOT_W-1:0] hash_home;
    logic              hash_done;
    mem_req_t          mem_req;
    entry_t            rd_data;

    // home slot: register the product, then add and mask
    lpht_hash u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (hash_start),
        .key       (hash_key),
        .home      (hash_home),
        .done      (hash_done)
    );

    // key and slot state, one entry per slot, registered read
    lpht_slot_mem u_mem (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    // sequencer: clearing pass, probe walk, live count, result register
    lpht_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (req.valid),
        .in_ready       (req.ready),
        .in_req_type    (req.req_type),
        .in_key         (req.key),
        .out_valid      (rsp.valid),
        .out_ready      (rsp.ready),
        .out_status     (rsp.status),
        .out_slot       (rsp.slot),
        .out_live_count (rsp.live_count),
        .hash_start     (hash_start),
        .hash_key       (hash_key),
        .hash_home      (hash_home),
        .hash_done      (hash_done),
        .mem_req        (mem_req),
        .rd_data        (rd_data)
    );

endmodule

/* hw/rtl/lpht_hash.sv */
module lpht_hash
    import lpht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              start,
    input  logic [KEY_W-1:0]  key,
    output logic [SLOT_W-1:0] home,
    output logic              done
);

    logic [CFG_W-1:0] mult_reg;
    logic [CFG_W-1:0] add_reg;
    logic [CFG_W-1:0] prod_reg;
    logic [CFG_W-1:0] prod_next;
    logic [CFG_W-1:0] sum;
    logic [SLOT_W-1:0] home_reg;
    logic             mul_vld_reg;
    logic             add_vld_reg;

    // stage one: wrapped 32-bit product; stage two: add and keep low bits
    assign prod_next = mult_reg * CFG_W'(key);
    assign sum       = prod_reg + add_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg    <= CFG_W'(1);
            add_reg     <= '0;
            mul_vld_reg <= 1'b0;
            add_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_HASH_MULT)
            begin
                mult_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_HASH_ADD)
            begin
                add_reg <= cfg_data;
            end
            mul_vld_reg <= start;
            add_vld_reg <= mul_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        home_reg <= sum[SLOT_W-1:0];
    end

    assign home = home_reg;
    assign done = add_vld_reg;

endmodule

/* hw/rtl/lpht_slot_mem.sv */
module lpht_slot_mem
    import lpht_pkg::*;
(
    input  logic     clk,
    input  mem_req_t mem_req,
    output entry_t   rd_data
);

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
        rd_data_reg <= mem[mem_req.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/lpht_seq.sv */
module lpht_seq
    import lpht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        in_req_type,
    input  logic [KEY_W-1:0]  in_key,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        out_status,
    output logic [SLOT_W-1:0] out_slot,
    output logic [CNT_W-1:0]  out_live_count,
    output logic              hash_start,
    output logic [KEY_W-1:0]  hash_key,
    input  logic [SLOT_W-1:0] hash_home,
    input  logic              hash_done,
    output mem_req_t          mem_req,
    input  entry_t            rd_data
);

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
    localparam logic [SLOT_W-1:0] STEP     = SLOT_W'(PROBE_STEP);

    seq_state_t        state_reg, state_next;
    logic [1:0]        op_reg, op_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [SLOT_W-1:0] probe_reg, probe_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  live_reg, live_next;
    logic [2:0]        res_status_reg, res_status_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic [SLOT_W-1:0] clr_reg, clr_next;
    logic              out_valid_reg, out_valid_next;
    logic [2:0]        out_status_reg, out_status_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic [CNT_W-1:0]  out_live_reg, out_live_next;
    logic [CNT_W-1:0]  cnt_inc;
    logic [2:0]        miss_status;
    logic              key_hit;

    assign cnt_inc = cnt_reg + CNT_W'(1);
    assign key_hit = (rd_data.state == SLOT_LIVE) && (rd_data.key == key_reg);

    always_comb
    begin
        case (op_reg)
            REQ_INSERT: miss_status = RES_FULL;
            REQ_DELETE: miss_status = RES_DEL_MISS;
            default:    miss_status = RES_NOT_FOUND;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        probe_next      = probe_reg;
        cnt_next        = cnt_reg;
        live_next       = live_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        clr_next        = clr_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_live_next   = out_live_reg;
        in_ready        = 1'b0;
        hash_start      = 1'b0;
        mem_req.we      = 1'b0;
        mem_req.waddr   = probe_reg;
        mem_req.wdata   = '{key: key_reg, state: SLOT_LIVE};
        mem_req.raddr   = probe_reg;

        case (state_reg)
            SEQ_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = clr_reg;
                mem_req.wdata = '{key: '0, state: SLOT_EMPTY};
                clr_next      = clr_reg + SLOT_W'(1);
                if (clr_reg == SLOT_W'(TABLE_DEPTH - 1))
                begin
                    state_next = SEQ_IDLE;
                end
            end
            SEQ_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next  = in_req_type;
                    key_next = in_key;
                    if (in_req_type == REQ_INSERT && live_reg == DEPTH_CNT)
                    begin
                        res_status_next = RES_FULL;
                        res_slot_next   = '0;
                        state_next      = SEQ_REPLY;
                    end
                    else
                    begin
                        hash_start = 1'b1;
                        state_next = SEQ_HASH;
                    end
                end
            end
            SEQ_HASH:
            begin
                if (hash_done)
                begin
                    probe_next = hash_home;
                    cnt_next   = '0;
                    state_next = SEQ_READ;
                end
            end
            SEQ_READ:
            begin
                state_next = SEQ_CHECK;
            end
            SEQ_CHECK:
            begin
                res_slot_next = probe_reg;
                state_next    = SEQ_REPLY;
                if (op_reg == REQ_INSERT && rd_data.state != SLOT_LIVE)
                begin
                    mem_req.we      = 1'b1;
                    live_next       = live_reg + CNT_W'(1);
                    res_status_next = RES_INSERTED;
                end
                else if (op_reg != REQ_INSERT && rd_data.state == SLOT_EMPTY)
                begin
                    res_status_next = miss_status;
                    res_slot_next   = '0;
                end
                else if (op_reg != REQ_INSERT && key_hit)
                begin
                    if (op_reg == REQ_DELETE)
                    begin
                        mem_req.we      = 1'b1;
                        mem_req.wdata   = '{key: key_reg, state: SLOT_DEAD};
                        if (live_reg != '0)
                        begin
                            live_next = live_reg - CNT_W'(1);
                        end
                        res_status_next = RES_DELETED;
                    end
                    else
                    begin
                        res_status_next = RES_FOUND;
                    end
                end
                else if (cnt_inc == DEPTH_CNT)
                begin
                    res_status_next = miss_status;
                    res_slot_next   = '0;
                end
                else
                begin
                    // advance along the probe path
                    cnt_next   = cnt_inc;
                    probe_next = probe_reg + STEP;
                    state_next = SEQ_READ;
                end
            end
            SEQ_REPLY:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    out_live_next   = live_reg;
                    state_next      = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_CLEAR;
            clr_reg       <= '0;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        probe_reg      <= probe_next;
        cnt_reg        <= cnt_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_live_reg   <= out_live_next;
    end

    // feed the incoming key in the accepting cycle so the product lines up with start
    assign hash_key       = key_next;
    assign out_valid      = out_valid_reg;
    assign out_status     = out_status_reg;
    assign out_slot       = out_slot_reg;
    assign out_live_count = out_live_reg;

endmodule

/* hw/rtl/lpht_checker.sv */
module lpht_checker
    import lpht_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [2:0]        out_status,
    input logic [SLOT_W-1:0] out_slot,
    input logic [CNT_W-1:0]  out_live_count
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_status)
            && $stable(out_slot) && $stable(out_live_count))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_status <= RES_DEL_MISS)
        else $error("status code out of range");

    a_miss_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status == RES_FULL || out_status == RES_NOT_FOUND
            || out_status == RES_DEL_MISS) |-> out_slot == '0)
        else $error("slot nonzero on a miss");

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_live_count <= CNT_W'(TABLE_DEPTH))
        else $error("live count above depth");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (req.valid),
    .in_ready       (req.ready),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .out_status     (rsp.status),
    .out_slot       (rsp.slot),
    .out_live_count (rsp.live_count)
);

/* test/tb.sv */
module tb;
    import lpht_pkg::*;

    // Request type 3 is not decoded by the block; it behaves as a search.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int IDLE_PCT     = 7;
    localparam int STALL_AT     = 120;   // responses seen before the long hold-off
    localparam int STALL_LEN    = 400;   // cycles the receiver holds ready low
    localparam int POOL_MAX     = 48;
    // Worst case is about 670 requests, each walking up to 1024 probes, plus the
    // clearing pass; allow a few times that.
    localparam int LIMIT_CYCLES = 12_000_000;
    localparam int DRAIN_CYCLES = 2100;  // longest probe walk plus margin

    typedef struct packed {
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
    } table_req_t;

    typedef struct packed {
        res_status_t       status;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  live_count;
    } table_answer_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;

    lpht_req_if req_ch ();
    lpht_rsp_if rsp_ch ();

    linear_probe_hash_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch.sink),
        .rsp       (rsp_ch.source)
    );

    // Shadow copy of the table: keys, per-slot status, live count and hash setup.
    logic [KEY_W-1:0] slot_key_m [TABLE_DEPTH];
    slot_state_t      slot_state_m [TABLE_DEPTH];
    int               live_now = 0;
    logic [31:0]      hash_mult_cur = 32'd1;
    logic [31:0]      hash_add_cur = 32'd0;

    table_req_t       requests_pending [$];
    table_answer_t    answers_due [$];
    logic [KEY_W-1:0] key_pool [$];
    table_req_t       next_req;
    table_answer_t    due_answer;

    int          n_issued = 0;
    int          n_accepted = 0;
    int          n_answers = 0;
    int          mismatches = 0;
    int unsigned run_cycles = 0;
    logic        req_taken = 1'b0;
    bit          no_gaps = 1'b0;
    bit          stall_done = 1'b0;
    int          stall_left = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Apply one request to the shadow table and return the response it must give.
    function automatic table_answer_t table_apply(logic [1:0] op, logic [KEY_W-1:0] k);
        table_answer_t     ans;
        logic [31:0]       hashed;
        logic [SLOT_W-1:0] home;
        logic [SLOT_W-1:0] pos;
        logic [SLOT_W-1:0] hit_pos;
        bit                hit;
        bit                stop;
        int                i;
        hashed   = hash_mult_cur * {1'b0, k} + hash_add_cur;
        home     = hashed[SLOT_W-1:0];
        ans.slot = '0;
        hit      = 1'b0;
        stop     = 1'b0;
        hit_pos  = '0;
        if (op == REQ_INSERT)
        begin
            ans.status = RES_FULL;
            if (live_now < TABLE_DEPTH)
            begin
                // take the first slot that is empty or a tombstone, home included
                for (i = 0; i < TABLE_DEPTH && !stop; i++)
                begin
                    pos = SLOT_W'(home + i * PROBE_STEP);
                    if (slot_state_m[pos] != SLOT_LIVE)
                    begin
                        slot_key_m[pos]   = k;
                        slot_state_m[pos] = SLOT_LIVE;
                        live_now++;
                        ans.slot   = pos;
                        ans.status = RES_INSERTED;
                        stop       = 1'b1;
                    end
                end
            end
        end
        else
        begin
            // walk past tombstones; an empty slot or a full lap ends the walk
            for (i = 0; i < TABLE_DEPTH && !stop; i++)
            begin
                pos = SLOT_W'(home + i * PROBE_STEP);
                if (slot_state_m[pos] == SLOT_EMPTY)
                    stop = 1'b1;
                else if (slot_state_m[pos] == SLOT_LIVE && slot_key_m[pos] == k)
                begin
                    hit     = 1'b1;
                    hit_pos = pos;
                    stop    = 1'b1;
                end
            end
            if (op == REQ_DELETE)
            begin
                ans.status = RES_DEL_MISS;
                if (hit)
                begin
                    slot_state_m[hit_pos] = SLOT_DEAD;
                    if (live_now > 0)
                        live_now--;
                    ans.slot   = hit_pos;
                    ans.status = RES_DELETED;
                end
            end
            else
            begin
                ans.status = hit ? RES_FOUND : RES_NOT_FOUND;
                ans.slot   = hit ? hit_pos : '0;
            end
        end
        ans.live_count = live_now[CNT_W-1:0];
        return ans;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        int          r;
        logic [31:0] w;
        r = $urandom_range(0, 99);
        w = $urandom;
        if (r < 65 && key_pool.size() != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        if (r < 72)
            return '0;
        if (r < 79)
            return {KEY_W{1'b1}};
        return w[KEY_W-1:0];
    endfunction

    // Queue one request; remember inserted keys so later searches and deletes hit.
    task automatic queue_request(logic [1:0] op, logic [KEY_W-1:0] k);
        table_req_t item;
        item.op  = op;
        item.key = k;
        requests_pending.push_back(item);
        n_issued++;
        if (op == REQ_INSERT)
        begin
            key_pool.push_back(k);
            if (key_pool.size() > POOL_MAX)
                void'(key_pool.pop_front());
        end
    endtask

    task automatic add_random_request();
        int         r;
        logic [1:0] op;
        r = $urandom_range(0, 99);
        if (r < 45)
            op = REQ_INSERT;
        else if (r < 70)
            op = REQ_SEARCH;
        else if (r < 93)
            op = REQ_DELETE;
        else
            op = REQ_UNUSED;
        queue_request(op, pick_key());
    endtask

    // Hold until every request went in and every response came back.
    task automatic wait_idle();
        while (n_accepted != n_issued || answers_due.size() != 0)
            @(negedge clk);
    endtask

    // Registers are only written with the block idle, so the shadow copy
    // can follow the write at once.
    task automatic write_reg(cfg_index_t idx, logic [31:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_HASH_MULT)
            hash_mult_cur = value;
        else
            hash_add_cur = value;
    endtask

    task automatic run_random_phase(logic [31:0] mult, logic [31:0] add, int count);
        write_reg(CFG_HASH_MULT, mult);
        write_reg(CFG_HASH_ADD, add);
        @(posedge clk);
        repeat (count)
            add_random_request();
        wait_idle();
    endtask

    // Sender: advance to the next request once the current one is taken,
    // otherwise hold valid and payload steady.
    always @(negedge clk)
    begin
        if (rst_n && (!req_ch.valid || req_taken))
        begin
            if (requests_pending.size() != 0 && (no_gaps || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                next_req = requests_pending.pop_front();
                req_ch.valid    <= 1'b1;
                req_ch.req_type <= next_req.op;
                req_ch.key      <= next_req.key;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Receiver: drop ready now and then, and once hold it low for a long
    // stretch so the block backs up into its request side.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!stall_done && n_answers >= STALL_AT)
            begin
                stall_left = STALL_LEN;
                stall_done = 1'b1;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Monitor: predict on each accepted request, check each accepted response
    // against the oldest prediction.
    always @(posedge clk)
    begin
        run_cycles++;
        if (run_cycles >= LIMIT_CYCLES)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else if (rst_n)
        begin
            req_taken <= req_ch.valid && req_ch.ready;
            if (req_ch.valid && req_ch.ready)
            begin
                answers_due.push_back(table_apply(req_ch.req_type, req_ch.key));
                n_accepted++;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                n_answers++;
                if (answers_due.size() == 0)
                begin
                    $error("response with no request outstanding: status %0d slot %0d count %0d",
                           rsp_ch.status, rsp_ch.slot, rsp_ch.live_count);
                    mismatches++;
                end
                else
                begin
                    due_answer = answers_due.pop_front();
                    if (rsp_ch.status !== due_answer.status)
                    begin
                        $error("status: expected %0d, got %0d", due_answer.status, rsp_ch.status);
                        mismatches++;
                    end
                    if (rsp_ch.slot !== due_answer.slot)
                    begin
                        $error("slot: expected %0d, got %0d", due_answer.slot, rsp_ch.slot);
                        mismatches++;
                    end
                    if (rsp_ch.live_count !== due_answer.live_count)
                    begin
                        $error("live_count: expected %0d, got %0d",
                               due_answer.live_count, rsp_ch.live_count);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial
    begin
        int s;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_INSERT;
        req_ch.key      = '0;
        rsp_ch.ready    = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_HASH_MULT;
        cfg_data        = '0;
        for (s = 0; s < TABLE_DEPTH; s++)
            slot_state_m[s] = SLOT_EMPTY;

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part on the reset hash (identity, no offset): empty-table
        // misses, duplicate insert, home collisions, tombstone reuse at home,
        // key zero, the widest key and the unused request code.
        queue_request(REQ_SEARCH, 31'd0);
        queue_request(REQ_DELETE, 31'd0);
        queue_request(REQ_INSERT, 31'd0);
        queue_request(REQ_INSERT, 31'd0);
        queue_request(REQ_SEARCH, 31'd0);
        queue_request(REQ_INSERT, 31'd1024);
        queue_request(REQ_DELETE, 31'd0);
        queue_request(REQ_SEARCH, 31'd0);
        queue_request(REQ_SEARCH, 31'd1024);
        queue_request(REQ_INSERT, 31'd2048);
        queue_request(REQ_INSERT, 31'h7FFF_FFFF);
        queue_request(REQ_SEARCH, 31'h7FFF_FFFF);
        queue_request(REQ_UNUSED, 31'h7FFF_FFFF);
        queue_request(REQ_UNUSED, 31'd5);
        queue_request(REQ_DELETE, 31'h7FFF_FFFF);
        queue_request(REQ_DELETE, 31'h7FFF_FFFF);
        queue_request(REQ_INSERT, 31'h5555_5555);
        queue_request(REQ_INSERT, 31'h2AAA_AAAA);
        queue_request(REQ_SEARCH, 31'h5555_5555);
        queue_request(REQ_DELETE, 31'h2AAA_AAAA);
        wait_idle();

        // Random phases across hash settings; the long receiver hold lands in
        // the first one, the second runs without any idle cycles.
        run_random_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 220);
        no_gaps = 1'b1;
        run_random_phase($urandom | 32'd1, $urandom, 150);
        no_gaps = 1'b0;
        // zero multiplier: every key shares one home slot
        run_random_phase(32'd0, $urandom, 50);
        run_random_phase($urandom & ~32'd1, 32'd0, 150);
        run_random_phase($urandom, $urandom, 80);

        // Let any stray response show up before judging.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
